/* sv/rrli_pkg.sv */
// shared types and constants for the round-robin list interleaver
// no dependencies; imported by every module of the block
`default_nettype none

package rrli_pkg;

    localparam int LISTS   = 8;
    localparam int DEPTH   = 256;
    localparam int QDEPTH  = 2;

    localparam int LIST_W  = $clog2(LISTS);
    localparam int CNT_W   = $clog2(LISTS + 1);
    localparam int LEN_W   = $clog2(DEPTH + 1);
    localparam int MEM_AW  = $clog2(LISTS * DEPTH);
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int CMP_W   = 8;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TAKE   = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_FULL        = 2'd1;
    localparam logic [1:0] ST_EMPTY       = 2'd2;
    localparam logic [1:0] ST_NOT_IN_USE  = 2'd3;

    localparam logic [3:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         list_id;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] word;
        logic [1:0]         status;
        logic               has_more;
    } result_t;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_CLEAR  = 3'd1,
        OP_APPEND = 3'd2,
        OP_REJECT = 3'd3,
        OP_TAKE   = 3'd4
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [2:0]         list_id;
        logic signed [31:0] value;
    } entry_t;

    function automatic logic [CNT_W-1:0] active_lists(input logic [3:0] cfg);
        logic [CMP_W-1:0] k;
        k = CMP_W'(cfg);
        if (k == '0)
        begin
            k = CMP_W'(1);
        end
        if (k > CMP_W'(LISTS))
        begin
            k = CMP_W'(LISTS);
        end
        return CNT_W'(k);
    endfunction

endpackage

`default_nettype wire

/* sv/round_robin_list_interleaver.sv */
// Round-robin list interleaver: up to eight lists of 32-bit words served in turn.
// Commands are taken when start is high and busy is low. Each command gives one
// result beat, shown for a single cycle with done high; the receiver cannot hold
// it off. With the command queue empty, a taken command passes the queue register
// and then the result registers before done rises, and one command per cycle is
// sustained: the back end executes a command (rotating pick over the eight list
// flags plus one registered read of the element store) and shows its result in
// the next cycle while it already executes the following command. busy rises only
// when the two-entry command queue is full. The element store is not cleared
// after reset and needs no clearing pass. The user must write lists_in_use through
// cfg_we and cfg_wdata only while no command is in flight; the block does not enforce it.
// depends on rrli_pkg, rrli_front, rrli_queue and rrli_back
`default_nettype none

module round_robin_list_interleaver
    import rrli_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire cmd_t       cmd,
    output logic            done,
    output result_t         result,
    input  wire logic       cfg_we,
    input  wire logic [3:0] cfg_wdata
);

    logic             push;
    entry_t           push_data;
    entry_t           head;
    logic             full;
    logic             empty;
    logic             pop;
    logic [CNT_W-1:0] k;

    assign busy = full;

    rrli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .full      (full),
        .push      (push),
        .push_data (push_data),
        .k         (k)
    );

    rrli_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    rrli_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .k      (k),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

/* sv/rrli_front.sv */
// front end: holds the list-count register, decodes and classifies commands
// depends on rrli_pkg
`default_nettype none

module rrli_front
    import rrli_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire cmd_t             cmd,
    input  wire logic             cfg_we,
    input  wire logic [3:0]       cfg_wdata,
    input  wire logic             full,
    output logic                  push,
    output entry_t                push_data,
    output logic [CNT_W-1:0]      k
);

    logic [3:0] cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    assign k    = active_lists(cfg_reg);
    assign push = start && !full;

    always_comb
    begin
        push_data.list_id = cmd.list_id;
        push_data.value   = cmd.value;
        case (cmd.action)
            ACT_CLEAR:
            begin
                push_data.op = OP_CLEAR;
            end
            ACT_APPEND:
            begin
                if (CMP_W'(cmd.list_id) < CMP_W'(k))
                begin
                    push_data.op = OP_APPEND;
                end
                else
                begin
                    push_data.op = OP_REJECT;
                end
            end
            ACT_TAKE:
            begin
                push_data.op = OP_TAKE;
            end
            default:
            begin
                push_data.op = OP_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/rrli_queue.sv */
// short fifo of classified commands between front and back
// depends on rrli_pkg
`default_nettype none

module rrli_queue
    import rrli_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_data,
    input  wire logic   pop,
    output entry_t      head,
    output logic        full,
    output logic        empty
);

    entry_t               q_reg [QDEPTH];
    logic [QPTR_W-1:0]    head_reg;
    logic [QPTR_W-1:0]    head_next;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic [QCNT_W:0]      tail_sum;
    logic [QPTR_W-1:0]    tail;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = q_reg[head_reg];

    always_comb
    begin
        tail_sum = (QCNT_W + 1)'(head_reg) + (QCNT_W + 1)'(count_reg);
        if (tail_sum >= (QCNT_W + 1)'(QDEPTH))
        begin
            tail_sum = tail_sum - (QCNT_W + 1)'(QDEPTH);
        end
        tail = QPTR_W'(tail_sum);

        head_next = head_reg;
        if (do_pop)
        begin
            if ((QCNT_W + 1)'(head_reg) + 1'b1 >= (QCNT_W + 1)'(QDEPTH))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = QPTR_W'(head_reg + 1'b1);
            end
        end

        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[tail] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* sv/rrli_back.sv */
// back end: list lengths, read positions, turn, element store and result beat
// depends on rrli_pkg
`default_nettype none

module rrli_back
    import rrli_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] k,
    input  wire entry_t           head,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  done,
    output result_t               result
);

    logic signed [31:0]   mem [LISTS * DEPTH];

    logic [LEN_W-1:0]     len_reg  [LISTS];
    logic [LEN_W-1:0]     len_next [LISTS];
    logic [LEN_W-1:0]     pos_reg  [LISTS];
    logic [LEN_W-1:0]     pos_next [LISTS];
    logic [LIST_W-1:0]    turn_reg;
    logic [LIST_W-1:0]    turn_next;

    logic                 done_reg;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic signed [31:0]   rdata_reg;

    logic [LISTS-1:0]     avail;
    logic [LISTS-1:0]     mask_hi;
    logic [LIST_W-1:0]    start_idx;
    logic [LIST_W-1:0]    pick;
    logic [LIST_W-1:0]    pick_hi;
    logic [LIST_W-1:0]    pick_lo;
    logic [LIST_W-1:0]    id;
    logic                 mem_we;
    logic                 mem_re;
    logic [MEM_AW-1:0]    waddr;
    logic [MEM_AW-1:0]    raddr;

    assign pop = !empty;
    assign id  = LIST_W'(head.list_id);

    always_comb
    begin
        for (int i = 0; i < LISTS; i++)
        begin
            avail[i] = (CNT_W'(i) < k) && (pos_reg[i] < len_reg[i]);
        end
        start_idx = (CNT_W'(turn_reg) < k) ? turn_reg : '0;
        for (int i = 0; i < LISTS; i++)
        begin
            mask_hi[i] = avail[i] && (LIST_W'(i) >= start_idx);
        end
        pick_hi = '0;
        pick_lo = '0;
        for (int i = LISTS - 1; i >= 0; i--)
        begin
            if (mask_hi[i])
            begin
                pick_hi = LIST_W'(i);
            end
            if (avail[i])
            begin
                pick_lo = LIST_W'(i);
            end
        end
        pick = (|mask_hi) ? pick_hi : pick_lo;
    end

    assign waddr = MEM_AW'(MEM_AW'(id) * MEM_AW'(DEPTH)) + MEM_AW'(len_reg[id]);
    assign raddr = MEM_AW'(MEM_AW'(pick) * MEM_AW'(DEPTH)) + MEM_AW'(pos_reg[pick]);

    always_comb
    begin
        len_next    = len_reg;
        pos_next    = pos_reg;
        turn_next   = turn_reg;
        status_next = ST_OK;
        hit_next    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (pop)
        begin
            case (head.op)
                OP_CLEAR:
                begin
                    for (int i = 0; i < LISTS; i++)
                    begin
                        len_next[i] = '0;
                        pos_next[i] = '0;
                    end
                    turn_next = '0;
                end
                OP_APPEND:
                begin
                    if (len_reg[id] >= LEN_W'(DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we       = 1'b1;
                        len_next[id] = LEN_W'(len_reg[id] + 1'b1);
                    end
                end
                OP_REJECT:
                begin
                    status_next = ST_NOT_IN_USE;
                end
                OP_TAKE:
                begin
                    if (|avail)
                    begin
                        mem_re         = 1'b1;
                        hit_next       = 1'b1;
                        pos_next[pick] = LEN_W'(pos_reg[pick] + 1'b1);
                        if (CNT_W'(pick) + 1'b1 == k)
                        begin
                            turn_next = '0;
                        end
                        else
                        begin
                            turn_next = LIST_W'(pick + 1'b1);
                        end
                    end
                    else
                    begin
                        status_next = ST_EMPTY;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LISTS; i++)
            begin
                len_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            turn_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            hit_reg    <= 1'b0;
        end
        else
        begin
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            turn_reg   <= turn_next;
            done_reg   <= pop;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= head.value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign done            = done_reg;
    assign result.word     = hit_reg ? rdata_reg : 32'sd0;
    assign result.status   = status_reg;
    assign result.has_more = |avail;

endmodule

`default_nettype wire

/* sv/rrli_checker.sv */
// port-level checks for the round-robin list interleaver, bound to the top level
// depends on rrli_pkg and round_robin_list_interleaver
`default_nettype none

module rrli_checker
    import rrli_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire result_t    result
);

    // a nonzero word only comes with a good take
    a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.word != 32'sd0) |-> (result.status == ST_OK))
        else $error("nonzero word with failing status");

    // an empty take leaves nothing behind
    a_empty_no_more: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_EMPTY) |-> !result.has_more)
        else $error("empty take reports remaining words");

    // the queue can only fill through a taken beat
    a_busy_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !busy)
        else $error("busy rose without a new command");

endmodule

bind round_robin_list_interleaver rrli_checker u_checker (.*);

`default_nettype wire
